### hw/rtl/lrgd_pkg.sv
// Shared types and constants for the linear regression gradient descent trainer.
package lrgd_pkg;

    localparam int XW     = 32;
    localparam int COST_W = 63;
    localparam int DVD_W  = 64;
    localparam int LR_W   = 32;
    localparam int ITER_W = 20;

    localparam logic [LR_W-1:0]   LR_RESET   = 32'd429497;
    localparam logic [ITER_W-1:0] ITER_RESET = 20'd100000;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_TRAIN   = 2'd1,
        MODE_PREDICT = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_LEARNING_RATE   = 1'b0,
        REG_ITERATION_COUNT = 1'b1
    } reg_index_t;

    typedef enum logic [4:0] {
        OP_NONE       = 5'd0,
        OP_CAPTURE    = 5'd1,
        OP_LOAD       = 5'd2,
        OP_CLEAR      = 5'd3,
        OP_READ       = 5'd4,
        OP_MUL_MX     = 5'd5,
        OP_FIT        = 5'd6,
        OP_ERR        = 5'd7,
        OP_MUL_ERR    = 5'd8,
        OP_ACC        = 5'd9,
        OP_EPOCH_INIT = 5'd10,
        OP_DIV_START  = 5'd11,
        OP_DIV_TAKE   = 5'd12,
        OP_STEP_HI    = 5'd13,
        OP_STEP_LO    = 5'd14,
        OP_STEP_APPLY = 5'd15,
        OP_EMIT       = 5'd16
    } op_t;

    typedef enum logic [1:0] {
        SEL_COST      = 2'd0,
        SEL_SLOPE     = 2'd1,
        SEL_INTERCEPT = 2'd2
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/lrgd_if.sv
// Request, response and configuration channel interfaces.
interface lrgd_req_if;
    import lrgd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic signed [XW-1:0] x_value;
    logic signed [XW-1:0] y_value;
    modport source (output valid, mode, x_value, y_value, input ready);
    modport sink (input valid, mode, x_value, y_value, output ready);
endinterface

interface lrgd_rsp_if;
    import lrgd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [XW-1:0] slope;
    logic signed [XW-1:0] intercept;
    logic [COST_W-1:0]    cost;
    logic signed [XW-1:0] prediction;
    modport source (output valid, status, slope, intercept, cost, prediction, input ready);
    modport sink (input valid, status, slope, intercept, cost, prediction, output ready);
endinterface

interface lrgd_cfg_if;
    import lrgd_pkg::*;
    logic            valid;
    logic            ready;
    logic [0:0]      index;
    logic [LR_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/linear_regression_gd_trainer.sv
// Linear regression trainer with batch gradient descent in signed Q16.16.
// Load and clear capture the request, update store or model, then emit the result.
// Predict forms slope * x plus intercept before it emits. During training,
// each point walks a 6-step sequence through the store read port and the multiplier,
// and each epoch runs three bit-serial divisions by the point count and two update steps.
// Reset empties the store, zeroes slope and intercept and loads default registers.
module linear_regression_gd_trainer #(
    parameter int MAX_POINTS = 32,
    parameter int DATA_WIDTH = 32
) (
    input logic         clk,
    input logic         rst_n,
    lrgd_req_if.sink    req,
    lrgd_rsp_if.source  rsp,
    lrgd_cfg_if.sink    cfg
);
    import lrgd_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [LR_W-1:0]   lr_reg;
    logic [ITER_W-1:0] iter_reg;
    cmd_t              cmd;
    dp_status_t        stat;
    logic [CW-1:0]     count;
    logic [AW-1:0]     rd_addr;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= LR_RESET;
            iter_reg <= ITER_RESET;
        end
        else if (cfg.valid)
        begin
            case (reg_index_t'(cfg.index))
                REG_LEARNING_RATE:   lr_reg   <= cfg.data;
                REG_ITERATION_COUNT: iter_reg <= cfg.data[ITER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lrgd_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req.valid),
        .req_mode        (req.mode),
        .req_ready       (req.ready),
        .iteration_count (iter_reg),
        .count           (count),
        .stat            (stat),
        .cmd             (cmd),
        .rd_addr         (rd_addr)
    );

    lrgd_dp #(
        .MAX_POINTS (MAX_POINTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .req_mode      (req.mode),
        .req_x         (req.x_value),
        .req_y         (req.y_value),
        .learning_rate (lr_reg),
        .stat          (stat),
        .count         (count),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .status        (rsp.status),
        .slope         (rsp.slope),
        .intercept     (rsp.intercept),
        .cost          (rsp.cost),
        .prediction    (rsp.prediction)
    );

endmodule

### hw/rtl/lrgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrgd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/lrgd_div.sv
// Restoring divider, one quotient bit per cycle, for a wide dividend by the point count.
module lrgd_div #(
    parameter int MAX_POINTS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lrgd_pkg::DVD_W-1:0]        dividend,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   divisor,
    output logic                              done,
    output logic [lrgd_pkg::DVD_W-1:0]        quotient
);
    import lrgd_pkg::*;

    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]    dsr_reg, dsr_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [CW:0]      shifted;
    logic [CW:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        shifted   = {rem_reg, dvd_reg[DVD_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dsr_next  = divisor;
            rem_next  = '0;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = trial[CW-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CW-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

### hw/rtl/lrgd_dp.sv
// Datapath: point store, model registers, error products, sums, step math and result register.
module lrgd_dp #(
    parameter int MAX_POINTS = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrgd_pkg::cmd_t                      cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
    input  logic [1:0]                          req_mode,
    input  logic signed [lrgd_pkg::XW-1:0]      req_x,
    input  logic signed [lrgd_pkg::XW-1:0]      req_y,
    input  logic [lrgd_pkg::LR_W-1:0]           learning_rate,
    output lrgd_pkg::dp_status_t                stat,
    output logic [$clog2(MAX_POINTS+1)-1:0]     count,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic [1:0]                          status,
    output logic signed [lrgd_pkg::XW-1:0]      slope,
    output logic signed [lrgd_pkg::XW-1:0]      intercept,
    output logic [lrgd_pkg::COST_W-1:0]         cost,
    output logic signed [lrgd_pkg::XW-1:0]      prediction
);
    import lrgd_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int VBITS = (DATA_WIDTH < XW) ? DATA_WIDTH : XW;
    localparam int SW    = 66;
    localparam int PW    = 2 * XW;
    localparam logic signed [SW-1:0] VMAX = (SW'(1) <<< (VBITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    function automatic logic signed [XW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [XW-1:0] r;
        if (v > VMAX)
        begin
            r = XW'(VMAX);
        end
        else if (v < VMIN)
        begin
            r = XW'(VMIN);
        end
        else
        begin
            r = v[XW-1:0];
        end
        return r;
    endfunction

    // control and model state
    logic [CW-1:0]         count_reg;
    logic signed [XW-1:0]  slope_reg;
    logic signed [XW-1:0]  intercept_reg;
    logic                  out_valid_reg, out_valid_next;

    // payload
    mode_t                 mode_reg;
    logic signed [XW-1:0]  cap_x_reg;
    logic signed [XW-1:0]  cap_y_reg;
    status_t               status_reg;
    logic signed [PW-1:0]  mx_reg;
    logic signed [XW-1:0]  fit_reg;
    logic signed [XW:0]    err_reg;
    logic signed [PW:0]    pxe_reg;
    logic [PW-1:0]         sq_reg;
    logic signed [PW-1:0]  acc_sxe_reg;
    logic signed [PW-1:0]  acc_se_reg;
    logic [PW-1:0]         acc_sq_reg;
    logic                  neg_reg;
    logic [DVD_W-1:0]      q_reg;
    logic [COST_W-1:0]     cost_reg;
    logic [PW-1:0]         phi_reg;
    logic [PW-1:0]         plo_reg;
    logic [1:0]            out_status_reg;
    logic signed [XW-1:0]  out_slope_reg;
    logic signed [XW-1:0]  out_intercept_reg;
    logic [COST_W-1:0]     out_cost_reg;
    logic signed [XW-1:0]  out_pred_reg;

    logic                  full;
    logic                  wr_en;
    logic                  rd_en;
    logic [PW-1:0]         rd_data;
    logic signed [XW-1:0]  pt_x;
    logic signed [XW-1:0]  pt_y;
    logic signed [XW-1:0]  mul_x;
    logic [XW-1:0]         err_mag;
    logic signed [PW-1:0]  gsum;
    logic signed [PW-1:0]  gval;
    logic                  gneg;
    logic [DVD_W-1:0]      dividend;
    logic                  div_done;
    logic [DVD_W-1:0]      quotient;
    logic [PW-1:0]         step_mag;
    logic signed [SW-1:0]  step_sw;
    logic signed [XW-1:0]  step_base;

    assign full  = count_reg == CW'(MAX_POINTS);
    assign wr_en = (cmd.op == OP_LOAD) && !full;
    assign rd_en = cmd.op == OP_READ;

    lrgd_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({cap_x_reg, cap_y_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pt_x    = rd_data[PW-1:XW];
    assign pt_y    = rd_data[XW-1:0];
    assign mul_x   = (mode_reg == MODE_TRAIN) ? pt_x : cap_x_reg;
    assign err_mag = err_reg[XW] ? XW'(-err_reg) : err_reg[XW-1:0];

    assign gsum     = (cmd.sel == SEL_SLOPE) ? acc_sxe_reg : acc_se_reg;
    assign gval     = gsum <<< 1;
    assign gneg     = (cmd.sel != SEL_COST) && gsum[PW-1];
    assign dividend = (cmd.sel == SEL_COST) ? (acc_sq_reg << 1)
                    : (gneg ? DVD_W'(-gval) : DVD_W'(gval));

    lrgd_div #(
        .MAX_POINTS (MAX_POINTS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV_START),
        .dividend (dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign step_mag  = phi_reg + (plo_reg >> XW);
    assign step_sw   = neg_reg ? -$signed({2'b00, step_mag}) : $signed({2'b00, step_mag});
    assign step_base = (cmd.sel == SEL_SLOPE) ? slope_reg : intercept_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            slope_reg     <= '0;
            intercept_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (cmd.op)
                OP_LOAD:
                begin
                    if (!full)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                OP_CLEAR:
                begin
                    count_reg     <= '0;
                    slope_reg     <= '0;
                    intercept_reg <= '0;
                end
                OP_STEP_APPLY:
                begin
                    if (cmd.sel == SEL_SLOPE)
                    begin
                        slope_reg <= sat(SW'(step_base) + step_sw);
                    end
                    else
                    begin
                        intercept_reg <= sat(SW'(step_base) + step_sw);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                mode_reg  <= mode_t'(req_mode);
                cap_x_reg <= req_x;
                cap_y_reg <= req_y;
                cost_reg  <= '0;
                fit_reg   <= '0;
                if ((mode_t'(req_mode) == MODE_LOAD) && full)
                begin
                    status_reg <= STATUS_FULL;
                end
                else if ((mode_t'(req_mode) == MODE_TRAIN) && (count_reg == '0))
                begin
                    status_reg <= STATUS_EMPTY;
                end
                else
                begin
                    status_reg <= STATUS_OK;
                end
            end
            OP_MUL_MX:
            begin
                mx_reg <= slope_reg * mul_x;
            end
            OP_FIT:
            begin
                fit_reg <= sat(SW'(mx_reg >>> 16) + SW'(intercept_reg));
            end
            OP_ERR:
            begin
                err_reg <= (XW+1)'(pt_y) - (XW+1)'(fit_reg);
            end
            OP_MUL_ERR:
            begin
                pxe_reg <= pt_x * err_reg;
                sq_reg  <= PW'(err_mag) * PW'(err_mag);
            end
            OP_EPOCH_INIT:
            begin
                acc_sxe_reg <= '0;
                acc_se_reg  <= '0;
                acc_sq_reg  <= '0;
            end
            OP_ACC:
            begin
                acc_sxe_reg <= acc_sxe_reg + PW'(pxe_reg >>> 16);
                acc_se_reg  <= acc_se_reg + PW'(err_reg);
                acc_sq_reg  <= acc_sq_reg + (sq_reg >> 16);
            end
            OP_DIV_START:
            begin
                neg_reg <= gneg;
            end
            OP_DIV_TAKE:
            begin
                if (cmd.sel == SEL_COST)
                begin
                    cost_reg <= quotient[DVD_W-1] ? '1 : quotient[COST_W-1:0];
                end
                else
                begin
                    q_reg <= quotient;
                end
            end
            OP_STEP_HI:
            begin
                phi_reg <= PW'(q_reg[DVD_W-1:XW]) * PW'(learning_rate);
            end
            OP_STEP_LO:
            begin
                plo_reg <= PW'(q_reg[XW-1:0]) * PW'(learning_rate);
            end
            OP_EMIT:
            begin
                out_status_reg    <= status_reg;
                out_slope_reg     <= slope_reg;
                out_intercept_reg <= intercept_reg;
                out_cost_reg      <= cost_reg;
                out_pred_reg      <= (mode_reg == MODE_PREDICT) ? fit_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.count_zero = count_reg == '0;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || rsp_ready;
    assign count           = count_reg;

    assign rsp_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slope      = out_slope_reg;
    assign intercept  = out_intercept_reg;
    assign cost       = out_cost_reg;
    assign prediction = out_pred_reg;

endmodule

### hw/rtl/lrgd_ctrl.sv
// Controller: request decode, point and epoch loops, divide and step sequencing.
module lrgd_ctrl #(
    parameter int MAX_POINTS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic [1:0]                         req_mode,
    output logic                               req_ready,
    input  logic [lrgd_pkg::ITER_W-1:0]        iteration_count,
    input  logic [$clog2(MAX_POINTS+1)-1:0]    count,
    input  lrgd_pkg::dp_status_t               stat,
    output lrgd_pkg::cmd_t                     cmd,
    output logic [$clog2(MAX_POINTS)-1:0]      rd_addr
);
    import lrgd_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_LOAD   = 18'h00002,
        S_CLEAR  = 18'h00004,
        S_PMUL   = 18'h00008,
        S_PFIT   = 18'h00010,
        S_EPOCH  = 18'h00020,
        S_READ   = 18'h00040,
        S_MUL    = 18'h00080,
        S_FIT    = 18'h00100,
        S_ERR    = 18'h00200,
        S_PROD   = 18'h00400,
        S_ACC    = 18'h00800,
        S_DSTART = 18'h01000,
        S_DWAIT  = 18'h02000,
        S_SHI    = 18'h04000,
        S_SLO    = 18'h08000,
        S_APPLY  = 18'h10000,
        S_EMIT   = 18'h20000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [ITER_W-1:0]   epoch_reg, epoch_next;
    sel_t                sel_reg, sel_next;

    assign req_ready = state_reg == S_IDLE;
    assign rd_addr   = idx_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        epoch_next = epoch_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op = OP_CAPTURE;
                    case (mode_t'(req_mode))
                        MODE_LOAD:    state_next = S_LOAD;
                        MODE_PREDICT: state_next = S_PMUL;
                        MODE_CLEAR:   state_next = S_CLEAR;
                        MODE_TRAIN:
                        begin
                            epoch_next = '0;
                            if (stat.count_zero || (iteration_count == '0))
                            begin
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_EPOCH;
                            end
                        end
                        default:      state_next = S_EMIT;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_EMIT;
            end
            S_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_EMIT;
            end
            S_PMUL:
            begin
                cmd.op     = OP_MUL_MX;
                state_next = S_PFIT;
            end
            S_PFIT:
            begin
                cmd.op     = OP_FIT;
                state_next = S_EMIT;
            end
            S_EPOCH:
            begin
                cmd.op     = OP_EPOCH_INIT;
                idx_next   = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.op     = OP_READ;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL_MX;
                state_next = S_FIT;
            end
            S_FIT:
            begin
                cmd.op     = OP_FIT;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.op     = OP_MUL_ERR;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op   = OP_ACC;
                idx_next = idx_reg + CW'(1);
                if ((idx_reg + CW'(1)) == count)
                begin
                    sel_next   = SEL_COST;
                    state_next = S_DSTART;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_DSTART:
            begin
                cmd.op     = OP_DIV_START;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op = OP_DIV_TAKE;
                    if (sel_reg == SEL_COST)
                    begin
                        sel_next   = SEL_SLOPE;
                        state_next = S_DSTART;
                    end
                    else
                    begin
                        state_next = S_SHI;
                    end
                end
            end
            S_SHI:
            begin
                cmd.op     = OP_STEP_HI;
                state_next = S_SLO;
            end
            S_SLO:
            begin
                cmd.op     = OP_STEP_LO;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.op = OP_STEP_APPLY;
                if (sel_reg == SEL_SLOPE)
                begin
                    sel_next   = SEL_INTERCEPT;
                    state_next = S_DSTART;
                end
                else
                begin
                    epoch_next = epoch_reg + ITER_W'(1);
                    if ((epoch_reg + ITER_W'(1)) == iteration_count)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_EPOCH;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            epoch_reg <= '0;
            sel_reg   <= SEL_COST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            epoch_reg <= epoch_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

### verif/lrgd_tb_pkg.sv
`timescale 1ns / 100ps
// Result record and table row types for the trainer testbench.
package lrgd_tb_pkg;
    import lrgd_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [XW-1:0]     slope;
        logic [XW-1:0]     intercept;
        logic [COST_W-1:0] cost;
        logic [XW-1:0]     prediction;
    } fit_result_t;

    typedef struct packed {
        mode_t         mode;
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        bit            typed;
        fit_result_t   fixed;
    } fit_row_t;
endpackage

### verif/linear_regression_gd_trainer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the gradient descent trainer: table plus random requests.
module linear_regression_gd_trainer_tb;
    import lrgd_pkg::*;
    import lrgd_tb_pkg::*;

    localparam int NPTS = 32;
    localparam int WATCH_LIMIT = 200000;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint unsigned M32 = 64'hFFFF_FFFF;
    localparam longint unsigned COST_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;
    lrgd_req_if req ();
    lrgd_rsp_if rsp ();
    lrgd_cfg_if cfg ();

    linear_regression_gd_trainer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    longint x_pts[NPTS];
    longint y_pts[NPTS];
    int unsigned pt_count;
    longint m_q;
    longint b_q;
    longint unsigned lr_q;
    int unsigned epochs_q;
    fit_result_t pending_fits[$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_stall;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clamp32(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic longint line_at(longint mv, longint bv, longint xv);
        return clamp32(((mv * xv) >>> 16) + bv);
    endfunction

    function automatic longint step_of(longint sum, longint unsigned n);
        longint g;
        bit neg;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned d;
        g = sum * 2;
        neg = g < 0;
        mag = neg ? longint'(-g) : g;
        q = mag / n;
        d = (q >> 32) * lr_q + (((q & M32) * lr_q) >> 32);
        return neg ? -longint'(d) : longint'(d);
    endfunction

    function automatic fit_result_t fit_step(mode_t mode, logic [31:0] xr, logic [31:0] yr);
        fit_result_t r;
        longint xv;
        longint yv;
        longint sxe;
        longint se;
        longint errv;
        longint unsigned ssq;
        longint unsigned mag;
        longint unsigned costv;
        longint predv;
        xv = longint'($signed(xr));
        yv = longint'($signed(yr));
        costv = 0;
        predv = 0;
        r.status = STATUS_OK;
        case (mode)
            MODE_LOAD:
            begin
                if (pt_count < NPTS)
                begin
                    x_pts[pt_count] = xv;
                    y_pts[pt_count] = yv;
                    pt_count++;
                end
                else
                    r.status = STATUS_FULL;
            end
            MODE_TRAIN:
            begin
                if (pt_count == 0)
                    r.status = STATUS_EMPTY;
                else
                    for (int e = 0; e < epochs_q; e++)
                    begin
                        sxe = 0;
                        se = 0;
                        ssq = 0;
                        for (int i = 0; i < pt_count; i++)
                        begin
                            errv = y_pts[i] - line_at(m_q, b_q, x_pts[i]);
                            mag = errv < 0 ? longint'(-errv) : errv;
                            ssq += (mag * mag) >> 16;
                            sxe += (x_pts[i] * errv) >>> 16;
                            se += errv;
                        end
                        costv = (ssq * 2) / pt_count;
                        if (costv > COST_MAX)
                            costv = COST_MAX;
                        m_q = clamp32(m_q + step_of(sxe, pt_count));
                        b_q = clamp32(b_q + step_of(se, pt_count));
                    end
            end
            MODE_PREDICT:
                predv = line_at(m_q, b_q, xv);
            default:
            begin
                pt_count = 0;
                m_q = 0;
                b_q = 0;
            end
        endcase
        r.slope = m_q[31:0];
        r.intercept = b_q[31:0];
        r.cost = costv[62:0];
        r.prediction = predv[31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        if (no_stall)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 1))
            return $urandom;
        return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endfunction

    task automatic send_request(mode_t mode, logic [31:0] xr, logic [31:0] yr, bit typed,
                                fit_result_t fixed);
        fit_result_t r;
        int gap;
        r = fit_step(mode, xr, yr);
        pending_fits.push_back(typed ? fixed : r);
        req.valid <= 1'b1;
        req.mode <= mode;
        req.x_value <= xr;
        req.y_value <= yr;
        do
            @(posedge clk);
        while (!req.ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_fits.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_LEARNING_RATE)
            lr_q = value;
        else
            epochs_q = value[19:0];
    endtask

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            if (pending_fits.size() == 0)
            begin
                $display("%0t: response with nothing expected", $time);
                errors++;
            end
            else
            begin
                fit_result_t w;
                w = pending_fits.pop_front();
                if (rsp.status !== w.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, w.status, rsp.status);
                    errors++;
                end
                if (rsp.slope !== w.slope)
                begin
                    $display("%0t: slope exp %h got %h", $time, w.slope, rsp.slope);
                    errors++;
                end
                if (rsp.intercept !== w.intercept)
                begin
                    $display("%0t: intercept exp %h got %h", $time, w.intercept, rsp.intercept);
                    errors++;
                end
                if (rsp.cost !== w.cost)
                begin
                    $display("%0t: cost exp %h got %h", $time, w.cost, rsp.cost);
                    errors++;
                end
                if (rsp.prediction !== w.prediction)
                begin
                    $display("%0t: prediction exp %h got %h", $time, w.prediction,
                             rsp.prediction);
                    errors++;
                end
            end
        end
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= (pick_gap() == 0);
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    fit_row_t fit_rows[17];
    fit_result_t zero_fit;

    initial
    begin
        fit_result_t empty_fit;
        logic [31:0] lr_set[9];
        int epoch_set[9];
        bit train_set[9];
        int sent;
        int nload;
        no_stall = 0;
        pt_count = 0;
        m_q = 0;
        b_q = 0;
        lr_q = LR_RESET;
        epochs_q = ITER_RESET;
        zero_fit = '0;
        empty_fit = '0;
        empty_fit.status = STATUS_EMPTY;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.mode = MODE_LOAD;
        req.x_value = '0;
        req.y_value = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_LEARNING_RATE;
        cfg.data = '0;

        fit_rows = '{
            '{MODE_PREDICT, 32'h0000_0000, 32'h0, 1'b1, zero_fit},
            '{MODE_PREDICT, 32'h7FFF_FFFF, 32'h0, 1'b1, zero_fit},
            '{MODE_TRAIN,   32'h0000_0000, 32'h0, 1'b1, empty_fit},
            '{MODE_LOAD,    32'h7FFF_FFFF, 32'h8000_0000, 1'b1, zero_fit},
            '{MODE_LOAD,    32'h8000_0000, 32'h7FFF_FFFF, 1'b1, zero_fit},
            '{MODE_LOAD,    32'h0000_0000, 32'h0000_0000, 1'b1, zero_fit},
            '{MODE_LOAD,    32'h0001_0000, 32'h0002_0000, 1'b1, zero_fit},
            '{MODE_TRAIN,   32'h0000_0000, 32'h0, 1'b0, zero_fit},
            '{MODE_PREDICT, 32'h7FFF_FFFF, 32'h0, 1'b0, zero_fit},
            '{MODE_PREDICT, 32'h8000_0000, 32'h0, 1'b0, zero_fit},
            '{MODE_PREDICT, 32'h0000_0000, 32'h0, 1'b0, zero_fit},
            '{MODE_TRAIN,   32'h0000_0000, 32'h0, 1'b0, zero_fit},
            '{MODE_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, zero_fit},
            '{MODE_PREDICT, 32'h0001_2345, 32'h0, 1'b1, zero_fit},
            '{MODE_LOAD,    32'hFFFF_FFFF, 32'h0000_0001, 1'b1, zero_fit},
            '{MODE_TRAIN,   32'h0000_0000, 32'h0, 1'b0, zero_fit},
            '{MODE_CLEAR,   32'h0000_0000, 32'h0, 1'b1, zero_fit}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_LEARNING_RATE, 32'hFFFF_FFFF);
        write_reg(REG_ITERATION_COUNT, 32'd1);
        foreach (fit_rows[i])
            send_request(fit_rows[i].mode, fit_rows[i].x, fit_rows[i].y, fit_rows[i].typed,
                         fit_rows[i].fixed);
        drain();

        lr_set = '{32'd0, 32'h0001_0000, 32'd429497, 32'h0100_0000, $urandom,
                   32'd429497, $urandom, 32'hFFFF_FFFF, $urandom_range(1, 32'h00FF_FFFF)};
        epoch_set = '{2, 1, 0, 3, 1, 1048575, 2, 3, 1};
        train_set = '{1, 1, 1, 1, 1, 0, 1, 1, 1};
        sent = 0;
        foreach (lr_set[p])
        begin
            write_reg(REG_LEARNING_RATE, lr_set[p]);
            write_reg(REG_ITERATION_COUNT, epoch_set[p]);
            for (int k = 0; k < 100; )
            begin
                no_stall = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 3) == 0)
                begin
                    send_request(MODE_CLEAR, pick_value(), pick_value(), 1'b0, zero_fit);
                    k++;
                end
                nload = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                    : $urandom_range(1, 8);
                repeat (nload)
                begin
                    send_request(MODE_LOAD, pick_value(), pick_value(), 1'b0, zero_fit);
                    k++;
                end
                repeat ($urandom_range(0, 2))
                begin
                    send_request(MODE_PREDICT, pick_value(), pick_value(), 1'b0, zero_fit);
                    k++;
                end
                if (train_set[p] || $urandom_range(0, 9) == 0)
                begin
                    if (train_set[p])
                    begin
                        send_request(MODE_TRAIN, pick_value(), pick_value(), 1'b0, zero_fit);
                        k++;
                    end
                end
                repeat ($urandom_range(1, 3))
                begin
                    send_request(MODE_PREDICT, pick_value(), pick_value(), 1'b0, zero_fit);
                    k++;
                end
                if ($urandom_range(0, 7) == 0)
                    drain();
            end
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
